// ===== hw/rtl/vctb_pkg.sv =====
// Shared constants, types and operation codes of the valve countdown timer bank.
`default_nettype none
package vctb_pkg;

  localparam int TIMER_COUNT  = 5;
  localparam int VALVE_REGS   = 5;
  localparam int OP_W         = 3;
  localparam int IDX_W        = 3;
  localparam int MASK_W       = 6;
  localparam int MINUTES_W    = 11;
  localparam int SECONDS_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int TPOS_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  localparam logic [MINUTES_W-1:0] MINUTES_CEIL = MINUTES_W'(1092);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = CFG_IDX_W'(5);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_ALL  = 3'd0,
    OP_START_ONE = 3'd1,
    OP_CLEAR_ONE = 3'd2,
    OP_TICK      = 3'd3,
    OP_QUERY     = 3'd4
  } op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vctb_in_if.sv =====
// Command channel of the timer bank: valid/ready plus the command fields.
`default_nettype none
interface vctb_in_if;
  import vctb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  valve_index;
  logic [MASK_W-1:0] active_mask;

  modport source (output valid, output operation, output valve_index,
                  output active_mask, input ready);
  modport sink   (input valid, input operation, input valve_index,
                  input active_mask, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vctb_out_if.sv =====
// Result channel of the timer bank: valid/ready plus the result fields.
`default_nettype none
interface vctb_out_if;
  import vctb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    expired_mask;
  logic [SECONDS_W-1:0] remaining_seconds;

  modport source (output valid, output expired_mask, output remaining_seconds,
                  input ready);
  modport sink   (input valid, input expired_mask, input remaining_seconds,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/valve_countdown_timer_bank_core.sv =====
// Top level of the valve countdown timer bank: sequencer over one shared timer update unit.
`default_nettype none
//
//  channel  | direction | transfer contents
//  ---------+-----------+-----------------------------------------------------
//  in_ch    | sink      | operation, valve_index, active_mask
//  out_ch   | source    | expired_mask, remaining_seconds (one per command)
//  cfg_*    | write     | cfg_index selects run minutes 1..5 or the limit
//
//  Each command is captured, then the sequencer walks the bank timer by timer
//  through the single update unit (load value, decrement, compare), and a final
//  step moves the result into the output register.
//  in_ch.ready is high only while the sequencer is idle; a result waiting on
//  out_ch does not block the next command, but a second finished result holds
//  in the final step until the output register is free.
//  Synchronous reset zeroes all timers and run minutes and sets the limit to 1092.
//
module valve_countdown_timer_bank_core (
  input  wire                              clk,
  input  wire                              rst_n,
  vctb_in_if.sink                          in_ch,
  vctb_out_if.source                       out_ch,
  input  wire                              cfg_we,
  input  wire  [vctb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [vctb_pkg::MINUTES_W-1:0]   cfg_data
);
  import vctb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

  state_t                 state_r;
  op_t                    op_r;
  logic [IDX_W-1:0]       idx_r;
  logic [MASK_W-1:0]      mask_r;
  logic [TPOS_W-1:0]      pos_r;
  logic [MASK_W-1:0]      exp_r;
  logic [SECONDS_W-1:0]   rem_r;
  logic [SECONDS_W-1:0]   secs_r [TIMER_COUNT];
  logic [MINUTES_W-1:0]   mins_r [VALVE_REGS];
  logic [MINUTES_W-1:0]   limit_r;
  logic                   out_valid_r;
  logic [MASK_W-1:0]      out_exp_r;
  logic [SECONDS_W-1:0]   out_rem_r;

  // Shared update unit signals
  logic [IDX_W-1:0]       num;
  logic [SECONDS_W-1:0]   cur;
  logic [MINUTES_W-1:0]   run_mins;
  logic [MINUTES_W-1:0]   eff_mins;
  logic [SECONDS_W:0]     load_wide;
  logic [SECONDS_W-1:0]   load_val;
  logic [SECONDS_W-1:0]   dec_val;
  logic [7:0]             mask_ext;
  logic [7:0]             bit_sel;
  logic                   hit;
  logic                   tick_on;
  logic                   wr_en;
  logic [SECONDS_W-1:0]   wr_val;
  logic [MASK_W-1:0]      exp_nxt;
  logic [SECONDS_W-1:0]   rem_nxt;
  logic                   walk_last;
  logic                   out_free;

  assign num       = IDX_W'(pos_r) + IDX_W'(1);
  assign cur       = secs_r[pos_r];
  assign walk_last = (pos_r == TPOS_W'(TIMER_COUNT - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // Run minutes of the walked timer; timers past the register file run for zero.
  always_comb begin
    run_mins = '0;
    if (num <= IDX_W'(VALVE_REGS))
      run_mins = mins_r[IDX_W'(num - IDX_W'(1))];
  end

  // Clamp to the limit and the ceiling, then scale minutes to seconds (x64 - x4).
  always_comb begin
    eff_mins = run_mins;
    if (eff_mins > limit_r)      eff_mins = limit_r;
    if (eff_mins > MINUTES_CEIL) eff_mins = MINUTES_CEIL;
    load_wide = {eff_mins, 6'b0} - {4'b0, eff_mins, 2'b0};
    load_val  = load_wide[SECONDS_W-1:0];
  end

  assign dec_val  = cur - SECONDS_W'(1);
  assign mask_ext = {{(8-MASK_W){1'b0}}, mask_r};
  assign bit_sel  = 8'(1) << num;
  assign hit      = (num == idx_r);
  // Only timers with a bit in the mask can tick; a stopped timer stays put.
  assign tick_on  = (num < IDX_W'(MASK_W)) && mask_ext[num] && (cur != '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_val  = '0;
    exp_nxt = exp_r;
    rem_nxt = rem_r;
    case (op_r)
      OP_LOAD_ALL: begin
        wr_en  = 1'b1;
        wr_val = load_val;
      end
      OP_START_ONE: begin
        wr_en  = hit;
        wr_val = load_val;
      end
      OP_CLEAR_ONE: begin
        wr_en  = hit;
      end
      OP_TICK: begin
        wr_en  = tick_on;
        wr_val = dec_val;
        if (tick_on && dec_val == '0)
          exp_nxt = exp_r | bit_sel[MASK_W-1:0];
      end
      OP_QUERY: begin
        if (hit) rem_nxt = cur;
      end
      default: ;
    endcase
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.expired_mask      = out_exp_r;
  assign out_ch.remaining_seconds = out_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      limit_r     <= MINUTES_CEIL;
      for (int i = 0; i < TIMER_COUNT; i++) secs_r[i] <= '0;
      for (int i = 0; i < VALVE_REGS; i++)  mins_r[i] <= '0;
    end else begin
      // Configuration writes land whenever they come; out-of-list indexes drop.
      if (cfg_we) begin
        if (cfg_index < CFG_IDX_W'(VALVE_REGS))
          mins_r[cfg_index] <= cfg_data;
        else if (cfg_index == REG_LIMIT)
          limit_r <= cfg_data;
      end

      // Drop the output once taken; the final step reloads it on its own.
      if (out_valid_r && out_ch.ready && state_r != ST_DONE)
        out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= op_t'(in_ch.operation);
            idx_r   <= in_ch.valve_index;
            mask_r  <= in_ch.active_mask;
            exp_r   <= '0;
            rem_r   <= '0;
            pos_r   <= '0;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          // Advance one timer per cycle through the shared unit.
          if (wr_en) secs_r[pos_r] <= wr_val;
          exp_r <= exp_nxt;
          rem_r <= rem_nxt;
          if (walk_last) state_r <= ST_DONE;
          else           pos_r   <= pos_r + TPOS_W'(1);
        end
        ST_DONE: begin
          // Hold until the output register is free, then publish.
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_exp_r   <= exp_r;
            out_rem_r   <= rem_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_walk_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> pos_r <= TPOS_W'(TIMER_COUNT - 1))
    else $error("timer walk position out of range");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_WALK && pos_r == '0)
    else $error("accepted command did not start the walk at timer one");

  a_exp_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && op_r != OP_TICK |-> out_exp_r == '0)
    else $error("expired mask set for a command other than tick");

  a_rem_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && op_r != OP_QUERY |-> out_rem_r == '0)
    else $error("remaining seconds set for a command other than query");

  a_secs_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cur <= SECONDS_W'(65520))
    else $error("timer count above the seconds ceiling");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the valve countdown timer bank core.
module tb;
  import vctb_pkg::*;

  localparam int SECS_PER_MIN  = 60;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 170;
  localparam int SETTLE_CYCLES = 16;      // lets the sequencer finish a command walk
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [MASK_W-1:0]    expired;
    logic [SECONDS_W-1:0] remaining;
  } timer_result_t;

  // Predicts the timer bank: shadow registers, shadow counters, and the queue
  // of results still owed by the block.
  class countdown_bank;
    logic [MINUTES_W-1:0] run_minutes [VALVE_REGS];
    logic [MINUTES_W-1:0] limit_minutes;
    logic [SECONDS_W-1:0] seconds_left [TIMER_COUNT];
    timer_result_t        pending_results [$];
    int                   mismatches;

    function new();
      foreach (run_minutes[i]) run_minutes[i] = '0;
      foreach (seconds_left[i]) seconds_left[i] = '0;
      limit_minutes = MINUTES_CEIL;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MINUTES_W-1:0] val);
      if (idx < VALVE_REGS) run_minutes[idx] = val;
      else if (idx == REG_LIMIT) limit_minutes = val;
    endfunction

    // Clamp to the limit and to the 16-bit ceiling, then convert to seconds.
    function logic [SECONDS_W-1:0] load_seconds(int num);
      int mins;
      mins = 0;
      if (num >= 1 && num <= VALVE_REGS) mins = run_minutes[num-1];
      if (mins > limit_minutes) mins = limit_minutes;
      if (mins > MINUTES_CEIL) mins = MINUTES_CEIL;
      return SECONDS_W'(mins * SECS_PER_MIN);
    endfunction

    function void accept_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic [MASK_W-1:0] mask);
      timer_result_t res;
      bit            idx_ok;
      res    = '0;
      idx_ok = (idx >= 1) && (idx <= TIMER_COUNT);
      case (op)
        OP_LOAD_ALL: begin
          for (int i = 1; i <= TIMER_COUNT; i++) seconds_left[i-1] = load_seconds(i);
        end
        OP_START_ONE: begin
          if (idx_ok) seconds_left[idx-1] = load_seconds(idx);
        end
        OP_CLEAR_ONE: begin
          if (idx_ok) seconds_left[idx-1] = '0;
        end
        OP_TICK: begin
          for (int i = 1; i <= TIMER_COUNT && i < MASK_W; i++) begin
            if (mask[i] && seconds_left[i-1] != 0) begin
              seconds_left[i-1] = seconds_left[i-1] - 1'b1;
              if (seconds_left[i-1] == 0) res.expired[i] = 1'b1;
            end
          end
        end
        OP_QUERY: begin
          if (idx_ok) res.remaining = seconds_left[idx-1];
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void accept_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result expired=%h remaining=%0d",
                   $realtime, got.expired, got.remaining);
        return;
      end
      want = pending_results.pop_front();
      if (got.expired !== want.expired || got.remaining !== want.remaining) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result mismatch expired exp=%h got=%h remaining exp=%0d got=%0d",
                   $realtime, want.expired, got.expired, want.remaining, got.remaining);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MINUTES_W-1:0] cfg_data;
  bit   hold_req;
  int   cycles;

  countdown_bank bank;

  vctb_in_if  cmd_if ();
  vctb_out_if res_if ();

  valve_countdown_timer_bank_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Register setting per phase; covers both extremes of the limit and
  // minute values past the ceiling so the clamp gets exercised.
  function automatic int phase_setting(int phase, int reg_idx);
    if (reg_idx == REG_LIMIT) begin
      case (phase)
        0: return MINUTES_CEIL;
        1: return 0;
        2: return 1;
        3: return 2**MINUTES_W - 1;
        4: return 2;
        default: return $urandom_range(0, 3);
      endcase
    end
    case (phase)
      1: return (reg_idx == 0) ? 2**MINUTES_W - 1 : $urandom_range(0, 2**MINUTES_W - 1);
      2: begin
        case (reg_idx)
          0: return 2**MINUTES_W - 1;
          1: return 1;
          2: return 0;
          3: return MINUTES_CEIL;
          default: return MINUTES_CEIL + 1;
        endcase
      end
      3: return (reg_idx == 4) ? 2**MINUTES_W - 1 : $urandom_range(0, 2);
      4: return $urandom_range(0, 3);
      5: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2**MINUTES_W - 1)
                                           : $urandom_range(0, 2);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Offer one command after an optional idle gap; return at the falling edge
  // after the transfer, with valid still high.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [MASK_W-1:0] mask, input int gap);
    if (gap != 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.operation   = op;
    cmd_if.valve_index = idx;
    cmd_if.active_mask = mask;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input int val);
    cfg_we    = 1'b1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data  = MINUTES_W'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the sequencer settle.
  task automatic wait_drain();
    cmd_if.valid = 1'b0;
    while (bank.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sample every transfer and register write at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) bank.set_register(cfg_index, cfg_data);
      if (cmd_if.valid && cmd_if.ready)
        bank.accept_command(cmd_if.operation, cmd_if.valve_index, cmd_if.active_mask);
      if (res_if.valid && res_if.ready)
        bank.accept_result('{expired: res_if.expired_mask,
                             remaining: res_if.remaining_seconds});
    end
  end

  // Bound the run in cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: bursts of ready broken by random stalls, occasionally a long
  // ready stretch, and one long hold-off on request so the block backs up.
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_if.ready = 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 200)) @(negedge clk);
        else repeat ($urandom_range(1, 24)) @(negedge clk);
        stall = pick_gap();
        if (stall != 0) begin
          res_if.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    int gap;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] mask;

    bank               = new();
    cycles             = 0;
    hold_req           = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = OP_LOAD_ALL;
    cmd_if.valve_index = '0;
    cmd_if.active_mask = '0;

    // Hold reset, then release it on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: out-of-range and in-range queries on a freshly reset bank.
    send_cmd(OP_QUERY, 0, 6'h3F, 0);
    send_cmd(OP_QUERY, 1, 6'h00, 0);
    send_cmd(OP_QUERY, IDX_W'(TIMER_COUNT), 6'h15, 0);
    send_cmd(OP_QUERY, IDX_W'(2**IDX_W - 1), 6'h2A, 0);
    // Unknown operation codes change nothing and answer zero.
    for (int u = OP_QUERY + 1; u < 2**OP_W; u++) send_cmd(OP_W'(u), IDX_W'(u), 6'h3F, 0);
    // Tick with every timer stopped at zero, then a load with zero minutes.
    send_cmd(OP_TICK, 0, 6'h3F, 0);
    send_cmd(OP_LOAD_ALL, 0, 6'h00, 0);
    wait_drain();

    // Minutes at one, at the register maximum, just past the ceiling, at the
    // ceiling, and zero; limit at its maximum so only the ceiling clamps.
    write_reg(0, 1);
    write_reg(1, 2**MINUTES_W - 1);
    write_reg(2, MINUTES_CEIL + 1);
    write_reg(3, MINUTES_CEIL);
    write_reg(4, 0);
    write_reg(REG_LIMIT, 2**MINUTES_W - 1);
    send_cmd(OP_LOAD_ALL, 0, 6'h00, 0);
    for (int v = 1; v <= TIMER_COUNT; v++) send_cmd(OP_QUERY, IDX_W'(v), 6'h00, 0);
    send_cmd(OP_START_ONE, 0, 6'h3F, 0);
    send_cmd(OP_START_ONE, IDX_W'(TIMER_COUNT + 1), 6'h3F, 0);
    send_cmd(OP_CLEAR_ONE, 2, 6'h00, 0);
    send_cmd(OP_QUERY, 2, 6'h00, 0);
    // Bit zero of the mask alone moves nothing; then tick every timer.
    send_cmd(OP_TICK, 0, 6'h01, 0);
    send_cmd(OP_TICK, 0, 6'h3E, 0);
    send_cmd(OP_QUERY, 1, 6'h00, 0);
    send_cmd(OP_START_ONE, 1, 6'h00, 0);
    send_cmd(OP_QUERY, 1, 6'h00, 0);
    wait_drain();

    // Random phases, each under its own register setting. Ticks dominate so
    // the one-minute timers run down to zero and expire.
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int ri = 0; ri <= REG_LIMIT; ri++) write_reg(ri, phase_setting(phase, ri));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Request the long hold-off once, while commands keep coming.
        if (phase == 2 && n == 40) hold_req = 1'b1;
        r    = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 2**IDX_W - 1))
                                           : IDX_W'($urandom_range(1, TIMER_COUNT));
        mask = ($urandom_range(0, 1) == 0) ? {MASK_W'($urandom_range(0, 1))} | 6'h3E
                                           : MASK_W'($urandom_range(0, 2**MASK_W - 1));
        if (r < 60)      op = OP_TICK;
        else if (r < 70) op = OP_START_ONE;
        else if (r < 77) op = OP_CLEAR_ONE;
        else if (r < 90) op = OP_QUERY;
        else if (r < 95) op = OP_LOAD_ALL;
        else             op = OP_W'($urandom_range(OP_QUERY + 1, 2**OP_W - 1));
        // Run phase three back to back on the command side.
        gap = (phase == 3) ? 0 : pick_gap();
        send_cmd(op, idx, mask, gap);
      end
      wait_drain();
    end

    if (bank.mismatches == 0 && bank.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
